@@ rtl/tbts_pkg.sv @@
// Package for the tangent-by-series block: fixed-point constants and the
// cell types. Used by the other files under rtl/.
package tbts_pkg;

    localparam int unsigned ANGLE_W     = 24;
    localparam int unsigned X_W         = 33;   // magnitude of x, Q3.30 (up to about pi/2)
    localparam int unsigned SUM_W       = 40;   // internal signed sums
    localparam int unsigned TAN_W       = 32;
    localparam int unsigned OUT_W       = 31;
    localparam int unsigned QW          = 48;   // quotient width before saturation
    localparam logic [24:0] RAD_K       = 25'd18740330;
    localparam logic [22:0] ANGLE_LIMIT = 23'd5898240;
    localparam logic signed [SUM_W-1:0] ONE_Q30 = 40'sd1073741824;

    // Data that moves from one series cell to the next.
    typedef struct packed {
        logic                    vld;
        logic [4:0]              n;       // clamped term count
        logic                    xneg;
        logic [X_W-1:0]          x2;
        logic [X_W-1:0]          smag;    // current sine term magnitude
        logic                    sneg;
        logic [X_W-1:0]          cmag;    // current cosine term magnitude
        logic                    cneg;
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] c;
    } t_cell;

    // Data that moves through the divider cells.
    typedef struct packed {
        logic                    vld;
        logic                    qneg;
        logic                    czero;
        logic                    sge0;
        logic [QW-1:0]           rem;
        logic [QW-1:0]           quo;
        logic [QW-1:0]           den;
        logic signed [OUT_W-1:0] s_sat;
        logic signed [OUT_W-1:0] c_sat;
    } t_div;

endpackage

@@ rtl/tbts_term_cell.sv @@
// One series cell: adds the sine and cosine terms of index K and forms the
// next terms over two pipeline stages. Depends on tbts_pkg.
module tbts_term_cell #(
    parameter int unsigned K = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbts_pkg::t_cell  i_cell,
    output tbts_pkg::t_cell  o_cell
);
    localparam int unsigned MS = 2 * K * (2 * K + 1);   // sine next-term divisor
    localparam int unsigned MC = (2 * K + 1) * (2 * K + 2);
    localparam int unsigned XW = tbts_pkg::X_W;
    // Reciprocals that give an exact floor division of any XW-bit value
    localparam int unsigned LS = $clog2(MS);
    localparam int unsigned LC = $clog2(MC);
    localparam logic [XW:0] RS =
        (XW+1)'(((64'd1 << (XW + LS)) + 64'(MS) - 64'd1) / 64'(MS));
    localparam logic [XW:0] RC =
        (XW+1)'(((64'd1 << (XW + LC)) + 64'(MC) - 64'd1) / 64'(MC));

    tbts_pkg::t_cell r_a, n_a, r_cell, n_cell;
    logic [2*XW-1:0] r_ps, r_pc, n_ps, n_pc;
    logic            r_act, n_act;
    logic [2*XW:0]   w_rs, w_rc, w_ms, w_mc;
    logic [XW-1:0]   w_ns, w_nc;

    // Stage one: accumulate the current terms and form the raw products.
    always_comb begin
        n_a   = i_cell;
        n_act = 6'(i_cell.n) >= 6'(K);
        n_ps  = (2*XW)'(i_cell.smag) * (2*XW)'(i_cell.x2);
        n_pc  = (2*XW)'(i_cell.cmag) * (2*XW)'(i_cell.x2);
        if (n_act) begin
            n_a.s = i_cell.sneg ? i_cell.s - tbts_pkg::SUM_W'(i_cell.smag)
                                : i_cell.s + tbts_pkg::SUM_W'(i_cell.smag);
            n_a.c = i_cell.cneg ? i_cell.c - tbts_pkg::SUM_W'(i_cell.cmag)
                                : i_cell.c + tbts_pkg::SUM_W'(i_cell.cmag);
            n_a.sneg = ~i_cell.sneg;
            n_a.cneg = ~i_cell.cneg;
        end
    end

    // Stage two: round off the 2^30 scale, then divide by the term divisor.
    always_comb begin
        n_cell = r_a;
        w_rs   = (2*XW+1)'(r_ps) + ((2*XW+1)'(MS) << 29);
        w_rc   = (2*XW+1)'(r_pc) + ((2*XW+1)'(MC) << 29);
        w_ns   = XW'(w_rs >> 30);
        w_nc   = XW'(w_rc >> 30);
        w_ms   = (2*XW+1)'(w_ns) * (2*XW+1)'(RS);
        w_mc   = (2*XW+1)'(w_nc) * (2*XW+1)'(RC);
        if (r_act) begin
            n_cell.smag = XW'(w_ms >> (XW + LS));
            n_cell.cmag = XW'(w_mc >> (XW + LC));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld    <= 1'b0;
            r_cell.vld <= 1'b0;
        end else begin
            r_a.vld    <= i_cell.vld;
            r_cell.vld <= r_a.vld;
        end
        r_a.n       <= n_a.n;
        r_a.xneg    <= n_a.xneg;
        r_a.x2      <= n_a.x2;
        r_a.smag    <= n_a.smag;
        r_a.sneg    <= n_a.sneg;
        r_a.cmag    <= n_a.cmag;
        r_a.cneg    <= n_a.cneg;
        r_a.s       <= n_a.s;
        r_a.c       <= n_a.c;
        r_act       <= n_act;
        r_ps        <= n_ps;
        r_pc        <= n_pc;
        r_cell.n    <= n_cell.n;
        r_cell.xneg <= n_cell.xneg;
        r_cell.x2   <= n_cell.x2;
        r_cell.smag <= n_cell.smag;
        r_cell.sneg <= n_cell.sneg;
        r_cell.cmag <= n_cell.cmag;
        r_cell.cneg <= n_cell.cneg;
        r_cell.s    <= n_cell.s;
        r_cell.c    <= n_cell.c;
    end

    assign o_cell = r_cell;
endmodule

@@ rtl/tbts_div_cell.sv @@
// One restoring-division cell: retires quotient bit B per cycle.
// Depends on tbts_pkg.
module tbts_div_cell #(
    parameter int unsigned B = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbts_pkg::t_div  i_d,
    output tbts_pkg::t_div  o_d
);
    tbts_pkg::t_div r_d, n_d;
    logic [tbts_pkg::QW+B:0] w_sh;
    logic take;

    always_comb begin
        n_d  = i_d;
        w_sh = (tbts_pkg::QW+B+1)'(i_d.den) << B;
        take = ({1'b0, i_d.rem} >= (tbts_pkg::QW+1)'(w_sh)) &&
               (w_sh[tbts_pkg::QW+B:tbts_pkg::QW] == '0);
        if (take) begin
            n_d.rem    = i_d.rem - tbts_pkg::QW'(w_sh);
            n_d.quo[B] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= i_d.vld;
        end
        r_d.qneg  <= n_d.qneg;
        r_d.czero <= n_d.czero;
        r_d.sge0  <= n_d.sge0;
        r_d.rem   <= n_d.rem;
        r_d.quo   <= n_d.quo;
        r_d.den   <= n_d.den;
        r_d.s_sat <= n_d.s_sat;
        r_d.c_sat <= n_d.c_sat;
    end

    assign o_d = r_d;
endmodule

@@ rtl/tangent_by_taylor_series_top.sv @@
// Top level of the tangent-by-series block: angle conversion, a chain of
// series cells, a chain of divider cells and output saturation.
// Depends on tbts_pkg, tbts_term_cell and tbts_div_cell.
//
// Usage:
//   Drive i_angle_deg and raise start; the word is taken on any edge with
//   start high and busy low. busy is always low: one word per cycle.
//   Each result appears on o_tan_value, o_sine_sum, o_cosine_sum and
//   o_overflow for one cycle with o_done high; it cannot be held off.
//   The pipeline holds three front stages (clamp, radian
//   multiply, square), two stages per series cell (products, then scaling
//   and division by the term divisor), a sign/abs stage, 48 divider cells
//   and one output stage. Throughput is one word per cycle, set by the
//   fully pipelined cell rows.
//   i_num_terms_we writes num_terms (reset 12); the user must do so only while the block
//   idles, and the block does not enforce it. Reset clears all valid flags in flight;
//   no word appears after reset until a new one is started.
module tangent_by_taylor_series_top #(
    parameter int unsigned MAX_TERMS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [23:0]  i_angle_deg,
    input  logic                i_num_terms_we,
    input  logic [4:0]          i_num_terms_wdata,
    output logic                o_done,
    output logic signed [31:0]  o_tan_value,
    output logic signed [30:0]  o_sine_sum,
    output logic signed [30:0]  o_cosine_sum,
    output logic                o_overflow
);
    localparam int unsigned QW = tbts_pkg::QW;

    logic [4:0] r_num_terms;
    logic       r_v0, r_v1, r_v2;
    logic       r_neg0, r_neg1, r_neg2;
    logic [22:0] r_ua;
    logic [tbts_pkg::X_W-1:0] r_xm, r_xm2;
    logic [tbts_pkg::X_W-1:0] r_x2;
    logic [4:0] r_n0, r_n1, r_n2;
    logic signed [24:0] w_a;
    logic [47:0] w_prod;
    logic [65:0] w_sq;
    logic [4:0]  w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= 5'd12;
        end else if (i_num_terms_we) begin
            r_num_terms <= i_num_terms_wdata;
        end
    end

    assign busy = 1'b0;

    always_comb begin
        w_a = 25'(i_angle_deg);
        if (w_a > $signed({2'b00, tbts_pkg::ANGLE_LIMIT})) begin
            w_a = $signed({2'b00, tbts_pkg::ANGLE_LIMIT});
        end else if (w_a < -$signed({2'b00, tbts_pkg::ANGLE_LIMIT})) begin
            w_a = -$signed({2'b00, tbts_pkg::ANGLE_LIMIT});
        end
        w_n = r_num_terms;
        if (w_n == 5'd0) begin
            w_n = 5'd1;
        end else if (32'(w_n) > MAX_TERMS) begin
            w_n = 5'(MAX_TERMS);
        end
        w_prod = 48'(r_ua) * 48'(tbts_pkg::RAD_K);
        w_sq   = 66'(r_xm) * 66'(r_xm);
    end

    // Front stages: clamp, radians, square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_neg0 <= w_a[24];
        r_ua   <= w_a[24] ? 23'(-w_a) : 23'(w_a);
        r_n0   <= w_n;
        r_neg1 <= r_neg0;
        r_n1   <= r_n0;
        r_xm   <= tbts_pkg::X_W'((w_prod + 48'd32768) >> 16);
        r_neg2 <= r_neg1;
        r_n2   <= r_n1;
        r_xm2  <= r_xm;
        r_x2   <= tbts_pkg::X_W'((w_sq + (66'd1 << 29)) >> 30);
    end

    tbts_pkg::t_cell w_cell [MAX_TERMS+1];

    always_comb begin
        w_cell[0].vld  = r_v2;
        w_cell[0].n    = r_n2;
        w_cell[0].xneg = r_neg2;
        w_cell[0].x2   = r_x2;
        w_cell[0].smag = r_xm2;
        w_cell[0].sneg = r_neg2;
        // first cosine term is 1 * x2 / 2, rounded
        w_cell[0].cmag = tbts_pkg::X_W'((34'(r_x2) + 34'd1) >> 1);
        w_cell[0].cneg = 1'b1;
        w_cell[0].s    = '0;
        w_cell[0].c    = tbts_pkg::ONE_Q30;
    end

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_term
        tbts_term_cell #(.K(g + 1)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (w_cell[g]),
            .o_cell (w_cell[g+1])
        );
    end

    // Sign, magnitude and saturation ahead of the divider.
    tbts_pkg::t_div r_d0;
    tbts_pkg::t_cell w_last;
    logic signed [tbts_pkg::SUM_W-1:0] w_s, w_c;
    logic [tbts_pkg::SUM_W-1:0] w_us, w_uc;

    function automatic logic signed [30:0] sat31(input logic signed [39:0] v);
        if (v > 40'sd1073741823) begin
            return 31'sd1073741823;
        end else if (v < -40'sd1073741824) begin
            return -31'sd1073741824;
        end
        return 31'(v);
    endfunction

    always_comb begin
        w_last = w_cell[MAX_TERMS];
        w_s    = w_last.s;
        w_c    = w_last.c;
        w_us   = w_s[tbts_pkg::SUM_W-1] ? 40'(-w_s) : 40'(w_s);
        w_uc   = w_c[tbts_pkg::SUM_W-1] ? 40'(-w_c) : 40'(w_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0.vld <= 1'b0;
        end else begin
            r_d0.vld <= w_last.vld;
        end
        r_d0.qneg  <= w_s[tbts_pkg::SUM_W-1] != w_c[tbts_pkg::SUM_W-1];
        r_d0.czero <= w_c == '0;
        r_d0.sge0  <= !w_s[tbts_pkg::SUM_W-1];
        r_d0.rem   <= (QW'(w_us) << 16) + QW'(w_uc >> 1);
        r_d0.quo   <= '0;
        r_d0.den   <= QW'(w_uc);
        r_d0.s_sat <= sat31(w_s);
        r_d0.c_sat <= sat31(w_c);
    end

    tbts_pkg::t_div w_d [QW+1];
    assign w_d[0] = r_d0;

    for (genvar b = 0; b < QW; b++) begin : g_div
        tbts_div_cell #(.B(QW - 1 - b)) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_d    (w_d[b]),
            .o_d    (w_d[b+1])
        );
    end

    tbts_pkg::t_div w_dl;
    logic signed [31:0] n_tan;
    logic               n_ovf;

    always_comb begin
        w_dl  = w_d[QW];
        n_ovf = 1'b0;
        if (w_dl.czero) begin
            n_ovf = 1'b1;
            n_tan = w_dl.sge0 ? 32'sh7FFFFFFF : 32'sh80000000;
        end else if (!w_dl.qneg && w_dl.quo > QW'(32'h7FFFFFFF)) begin
            n_ovf = 1'b1;
            n_tan = 32'sh7FFFFFFF;
        end else if (w_dl.qneg && w_dl.quo > QW'(33'h080000000)) begin
            n_ovf = 1'b1;
            n_tan = 32'sh80000000;
        end else begin
            n_tan = w_dl.qneg ? 32'(-w_dl.quo) : 32'(w_dl.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_dl.vld;
        end
        o_tan_value  <= n_tan;
        o_sine_sum   <= w_dl.s_sat;
        o_cosine_sum <= w_dl.c_sat;
        o_overflow   <= n_ovf;
    end

    a_busy_low: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result after reset");
    a_czero_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dl.vld && w_dl.czero) |=> o_overflow)
        else $error("zero cosine without overflow");
endmodule

@@ test/tbts_checker.sv @@
// Checker for the tangent-by-series block: predicts each result from the
// accepted angle words and compares it with the result words seen.
// Uses no tbts_pkg declarations; the prediction is self-contained.
`timescale 1ns / 100ps

module tbts_checker #(
    parameter int unsigned MAX_TERMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [23:0] i_angle_deg,
    input  logic               i_num_terms_we,
    input  logic [4:0]         i_num_terms_wdata,
    input  logic               o_done,
    input  logic signed [31:0] o_tan_value,
    input  logic signed [30:0] o_sine_sum,
    input  logic signed [30:0] o_cosine_sum,
    input  logic               o_overflow,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 ovf_count
);

    typedef struct packed {
        logic signed [31:0] tanv;
        logic signed [30:0] sine;
        logic signed [30:0] cosine;
        logic               ovf;
    } t_tan_word;

    t_tan_word   tan_q[$];
    logic [4:0]  terms_reg;

    function automatic longint unsigned series_term(longint unsigned mag,
            longint unsigned x2, longint unsigned m);
        longint unsigned den;
        logic [127:0] prod;
        den  = (m * (m + 1)) << 30;
        prod = 128'(mag) * 128'(x2) + 128'(den / 2);
        return longint'(prod / 128'(den));
    endfunction

    function automatic logic signed [30:0] sat_q30(longint v);
        if (v > 64'sd1073741823) return 31'sd1073741823;
        if (v < -64'sd1073741824) return -31'sd1073741824;
        return v[30:0];
    endfunction

    function automatic t_tan_word predict_tangent(logic signed [23:0] ang,
            logic [4:0] terms);
        t_tan_word       r;
        longint          a, s, c;
        longint unsigned ua, xm, x2, mag, n, us, uc, q;
        bit              xneg, neg, qneg;
        a = ang;
        if (a > 5898240) a = 5898240;
        if (a < -5898240) a = -5898240;
        xneg = a < 0;
        ua = xneg ? -a : a;
        xm = (ua * 64'd18740330 + 32768) >> 16;
        x2 = (xm * xm + (64'd1 << 29)) >> 30;
        n = terms;
        if (n < 1) n = 1;
        if (n > MAX_TERMS) n = MAX_TERMS;
        s = 0; mag = xm; neg = xneg;
        for (longint unsigned k = 1; k <= n; k++) begin
            s += neg ? -longint'(mag) : longint'(mag);
            if (k < n) begin
                mag = series_term(mag, x2, 2 * k);
                neg = !neg;
            end
        end
        c = 64'sd1073741824; mag = 64'd1073741824; neg = 0;
        for (longint unsigned k = 1; k <= n; k++) begin
            mag = series_term(mag, x2, 2 * k - 1);
            neg = !neg;
            c += neg ? -longint'(mag) : longint'(mag);
        end
        r.ovf = 0;
        if (c == 0) begin
            r.ovf  = 1;
            r.tanv = (s >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        end else begin
            qneg = (s < 0) != (c < 0);
            us = s < 0 ? -s : s;
            uc = c < 0 ? -c : c;
            q = ((us << 16) + uc / 2) / uc;
            if (!qneg && q > 64'd2147483647) begin
                r.ovf = 1; r.tanv = 32'sh7FFFFFFF;
            end else if (qneg && q > 64'd2147483648) begin
                r.ovf = 1; r.tanv = 32'sh80000000;
            end else begin
                r.tanv = qneg ? -longint'(q) : longint'(q);
            end
        end
        r.sine   = sat_q30(s);
        r.cosine = sat_q30(c);
        return r;
    endfunction

    assign pending_count = tan_q.size();

    always @(posedge i_clk) begin
        t_tan_word exp_w;
        if (!i_rst_n) begin
            terms_reg <= 5'd12;
            tan_q.delete();
            fail_count   <= 0;
            result_count <= 0;
            ovf_count    <= 0;
        end else begin
            if (i_num_terms_we) terms_reg <= i_num_terms_wdata;
            if (start && !busy) tan_q.push_back(predict_tangent(i_angle_deg, terms_reg));
            if (o_done) begin
                result_count <= result_count + 1;
                if (o_overflow) ovf_count <= ovf_count + 1;
                if (tan_q.size() == 0) begin
                    $display("%0t: result word with none expected", $time);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = tan_q.pop_front();
                    if (exp_w.tanv !== o_tan_value || exp_w.sine !== o_sine_sum ||
                            exp_w.cosine !== o_cosine_sum || exp_w.ovf !== o_overflow) begin
                        $display("%0t: mismatch expected tan=%0d sin=%0d cos=%0d ovf=%0d",
                            $time, exp_w.tanv, exp_w.sine, exp_w.cosine, exp_w.ovf);
                        $display("%0t:          actual   tan=%0d sin=%0d cos=%0d ovf=%0d",
                            $time, o_tan_value, o_sine_sum, o_cosine_sum, o_overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the tangent-by-series testbench: clock, reset, angle and term-count
// stimulus, and the verdict. Depends on tangent_by_taylor_series_top and
// tbts_checker.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned MAX_TERMS = 16;
    localparam int          LATENCY   = 2 * MAX_TERMS + 52;
    localparam longint      CYCLE_LIMIT = 400000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [23:0] i_angle_deg = '0;
    logic               i_num_terms_we = 0;
    logic [4:0]         i_num_terms_wdata = '0;
    logic               o_done;
    logic signed [31:0] o_tan_value;
    logic signed [30:0] o_sine_sum;
    logic signed [30:0] o_cosine_sum;
    logic               o_overflow;
    int                 fail_count, pending_count, result_count, ovf_count;
    longint             cycle_count = 0;
    int                 angles_sent = 0;

    always #5 i_clk = ~i_clk;

    tangent_by_taylor_series_top #(.MAX_TERMS(MAX_TERMS)) DUT (.*);

    tbts_checker #(.MAX_TERMS(MAX_TERMS)) u_checker (.*);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Hold start high until the word is taken.
    task automatic send_angle(logic signed [23:0] ang);
        start       <= 1'b1;
        i_angle_deg <= ang;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        angles_sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
        if (n > 0) begin
            start       <= 1'b0;
            i_angle_deg <= 24'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drain every expected word, let the pipe empty, then write the term count.
    task automatic set_terms(logic [4:0] terms);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_num_terms_we    <= 1'b1;
        i_num_terms_wdata <= terms;
        @(posedge i_clk);
        i_num_terms_we    <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_angle();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);                          // any bit pattern
            1:       return $urandom_range(0, 1) ? 24'sd5898240 - 24'($urandom_range(0, 3000))
                                                 : -24'sd5898240 + 24'($urandom_range(0, 3000));
            default: return 24'($signed(33'($urandom_range(0, 11796480)) - 33'sd5898240));
        endcase
    endfunction

    initial begin
        logic [4:0] phase_terms [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd9};
        logic signed [23:0] directed [12] = '{
            24'sd0, 24'sd5898240, -24'sd5898240, 24'sd5898239, -24'sd5898239,
            24'sd1, -24'sd1, 24'sh7FFFFF, 24'sh800000, 24'sd2949120,
            -24'sd2949120, 24'sd65536};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed angles at the reset term count and at the extremes.
        foreach (directed[i]) send_angle(directed[i]);
        set_terms(5'd1);
        foreach (directed[i]) send_angle(directed[i]);

        foreach (phase_terms[p]) begin
            set_terms(phase_terms[p]);
            for (int i = 0; i < 210; i++) begin
                send_angle(rand_angle());
                if ($urandom_range(0, 2) != 0) idle_gap();
            end
        end
        set_terms(5'd12);
        for (int i = 0; i < 30; i++) send_angle(rand_angle());
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        $display("Sent %0d angles over term counts 0..31, %0d results, %0d with overflow",
            angles_sent, result_count, ovf_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tbts_pkg.sv
rtl/tbts_term_cell.sv
rtl/tbts_div_cell.sv
rtl/tangent_by_taylor_series_top.sv
test/tbts_checker.sv
test/testbench.sv
